/* hdl/dsrv_pkg.sv */
// Shared types and constants for the dual-slot record validator.
// No dependencies; used by every module of the block.
`default_nettype none

package dsrv_pkg;

    localparam int unsigned HDR_BYTES = 16;
    localparam int unsigned COUNT_W   = 17;
    localparam int unsigned LEN_W     = 17;

    localparam logic [31:0]        REC_MAGIC = 32'h5649_4146;
    localparam logic [31:0]        CRC_POLY  = 32'hEDB8_8320;
    localparam logic [31:0]        CRC_INIT  = 32'hFFFF_FFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        KIND_REC    = 2'd0,
        KIND_ERASE  = 2'd1,
        KIND_COMMIT = 2'd2
    } t_kind;

    localparam logic [1:0] ACT_A    = 2'd0;
    localparam logic [1:0] ACT_B    = 2'd1;
    localparam logic [1:0] ACT_NONE = 2'd2;

    typedef struct packed {
        logic        ok;
        logic [31:0] generation;
    } t_verdict;

    typedef struct packed {
        logic rec_last;
        logic erase;
        logic commit;
        logic slot;
    } t_slot_cmd;

    typedef struct packed {
        logic        record_valid;
        logic [1:0]  active_slot;
        logic [31:0] active_generation;
        logic [31:0] next_generation;
        logic        next_slot;
    } t_result;

endpackage

`default_nettype wire

/* hdl/dsrv_stream.sv */
// Record stream state: byte count, header capture and payload CRC-32.
// Produces the record verdict for the current byte. Depends on dsrv_pkg.
`default_nettype none

module dsrv_stream #(
    parameter int unsigned MAX_PAYLOAD_BYTES = 65536
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_step,
    input  wire logic                        i_clear,
    input  wire logic [7:0]                  i_data,
    input  wire logic                        i_last,
    input  wire logic [dsrv_pkg::LEN_W-1:0]  i_record_length,
    output dsrv_pkg::t_verdict               o_verdict
);

    logic [dsrv_pkg::COUNT_W-1:0] r_count;
    logic [dsrv_pkg::COUNT_W-1:0] n_count;
    logic [31:0]                  r_hdr [0:3];
    logic [31:0]                  n_hdr [0:3];
    logic [31:0]                  r_crc;
    logic [31:0]                  n_crc;
    logic                         w_in_hdr;
    logic                         w_in_payload;
    logic [dsrv_pkg::COUNT_W-1:0] w_pay_pos;

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] v;
        v = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            v = v[0] ? ((v >> 1) ^ dsrv_pkg::CRC_POLY) : (v >> 1);
        end
        return v;
    endfunction

    assign w_in_hdr     = (r_count < dsrv_pkg::COUNT_W'(dsrv_pkg::HDR_BYTES));
    assign w_pay_pos    = r_count - dsrv_pkg::COUNT_W'(dsrv_pkg::HDR_BYTES);
    assign w_in_payload = !w_in_hdr && (w_pay_pos < i_record_length);

    always_comb begin
        n_hdr = r_hdr;
        if (w_in_hdr) begin
            n_hdr[r_count[3:2]][{r_count[1:0], 3'b000} +: 8] = i_data;
        end
        n_crc   = w_in_payload ? crc_byte(r_crc, i_data) : r_crc;
        n_count = (r_count == dsrv_pkg::COUNT_MAX) ? r_count
                                                   : r_count + dsrv_pkg::COUNT_W'(1);
    end

    always_comb begin
        o_verdict.ok = (n_hdr[0] == dsrv_pkg::REC_MAGIC)
            && (n_hdr[2] == 32'(i_record_length))
            && (32'(i_record_length) <= 32'(MAX_PAYLOAD_BYTES))
            && ({1'b0, n_count} >= (18'(dsrv_pkg::HDR_BYTES) + {1'b0, i_record_length}))
            && (n_crc == n_hdr[3]);
        o_verdict.generation = n_hdr[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear || (i_step && i_last)) begin
            r_count <= '0;
            r_crc   <= dsrv_pkg::CRC_INIT;
            for (int i = 0; i < 4; i++) begin
                r_hdr[i] <= '0;
            end
        end else if (i_step) begin
            r_count <= n_count;
            r_crc   <= n_crc;
            r_hdr   <= n_hdr;
        end
    end

endmodule

`default_nettype wire

/* hdl/dsrv_slots.sv */
// Slot verdict and generation store, active slot selection and result build.
// Depends on dsrv_pkg.
`default_nettype none

module dsrv_slots (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire dsrv_pkg::t_slot_cmd i_cmd,
    input  wire dsrv_pkg::t_verdict  i_verdict,
    output dsrv_pkg::t_result        o_result
);

    logic [1:0]  r_ok;
    logic [1:0]  n_ok;
    logic [31:0] r_gen [0:1];
    logic [31:0] n_gen [0:1];
    logic [1:0]  w_old_act;
    logic [31:0] w_old_gen;
    logic [31:0] w_old_next;
    logic        w_tgt;
    logic [1:0]  w_new_act;
    logic [31:0] w_new_gen;

    function automatic logic [1:0] pick(input logic [1:0] ok, input logic [31:0] g0,
                                        input logic [31:0] g1);
        logic [31:0] d;
        logic [1:0]  act;
        d = g0 - g1;
        if (ok[0] && ok[1]) begin
            act = ((d != 32'd0) && !d[31]) ? dsrv_pkg::ACT_A : dsrv_pkg::ACT_B;
        end else if (ok[0]) begin
            act = dsrv_pkg::ACT_A;
        end else if (ok[1]) begin
            act = dsrv_pkg::ACT_B;
        end else begin
            act = dsrv_pkg::ACT_NONE;
        end
        return act;
    endfunction

    always_comb begin
        w_old_act  = pick(r_ok, r_gen[0], r_gen[1]);
        w_old_gen  = (w_old_act == dsrv_pkg::ACT_A) ? r_gen[0] :
                     (w_old_act == dsrv_pkg::ACT_B) ? r_gen[1] : 32'd0;
        w_old_next = w_old_gen + 32'd1;
        w_tgt      = !w_old_next[0];

        n_ok  = r_ok;
        n_gen = r_gen;
        if (i_cmd.erase) begin
            n_ok     = 2'b00;
            n_gen[0] = '0;
            n_gen[1] = '0;
        end else if (i_cmd.rec_last) begin
            n_ok[i_cmd.slot]  = i_verdict.ok;
            n_gen[i_cmd.slot] = i_verdict.ok ? i_verdict.generation : 32'd0;
        end else if (i_cmd.commit) begin
            n_ok[w_tgt]  = 1'b1;
            n_gen[w_tgt] = w_old_next;
        end

        w_new_act = pick(n_ok, n_gen[0], n_gen[1]);
        w_new_gen = (w_new_act == dsrv_pkg::ACT_A) ? n_gen[0] :
                    (w_new_act == dsrv_pkg::ACT_B) ? n_gen[1] : 32'd0;

        o_result.record_valid      = i_cmd.rec_last && i_verdict.ok;
        o_result.active_slot       = w_new_act;
        o_result.active_generation = w_new_gen;
        o_result.next_generation   = w_new_gen + 32'd1;
        o_result.next_slot         = !o_result.next_generation[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok     <= 2'b00;
            r_gen[0] <= '0;
            r_gen[1] <= '0;
        end else if (i_cmd.erase || i_cmd.rec_last || i_cmd.commit) begin
            r_ok  <= n_ok;
            r_gen <= n_gen;
        end
    end

endmodule

`default_nettype wire

/* hdl/dual_slot_record_validator.sv */
// Dual-slot record validator top level: input register, stream and slot logic,
// result register. Depends on dsrv_pkg, dsrv_stream and dsrv_slots.
// Accepted requests go to the input register; results go to the result register.
// Throughput: one request per cycle while o_stall is low; the CRC byte update and
// slot selection sit between the input register and the result register.
// Synchronous active-low reset: both slots invalid, stream cleared, length 1024.
`default_nettype none

module dual_slot_record_validator #(
    parameter int unsigned MAX_PAYLOAD_BYTES = 65536
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic [1:0]                 i_kind,
    input  wire logic                       i_slot,
    input  wire logic [7:0]                 i_data,
    input  wire logic                       i_last,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [dsrv_pkg::LEN_W-1:0] i_cfg_data,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic                            o_record_valid,
    output logic [1:0]                      o_active_slot,
    output logic [31:0]                     o_active_generation,
    output logic [31:0]                     o_next_generation,
    output logic                            o_next_slot
);

    logic [dsrv_pkg::LEN_W-1:0] r_record_length;
    logic                       r_in_valid;
    logic [1:0]                 r_in_kind;
    logic                       r_in_slot;
    logic [7:0]                 r_in_data;
    logic                       r_in_last;
    logic                       w_is_rec;
    logic                       w_produces;
    logic                       w_proc;
    logic                       w_accept;
    dsrv_pkg::t_slot_cmd        w_cmd;
    dsrv_pkg::t_verdict         w_verdict;
    dsrv_pkg::t_result          w_result;
    dsrv_pkg::t_result          r_out;
    logic                       r_out_valid;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_record_length <= dsrv_pkg::LEN_W'(1024);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_record_length <= i_cfg_data;
        end
    end

    assign w_is_rec   = (r_in_kind == dsrv_pkg::KIND_REC);
    assign w_produces = (w_is_rec && r_in_last) || (r_in_kind == dsrv_pkg::KIND_ERASE)
                        || (r_in_kind == dsrv_pkg::KIND_COMMIT);
    assign w_proc     = r_in_valid && (!w_produces || !r_out_valid || !i_stall);
    assign o_stall    = r_in_valid && !w_proc;
    assign w_accept   = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_kind <= i_kind;
            r_in_slot <= i_slot;
            r_in_data <= i_data;
            r_in_last <= i_last;
        end
    end

    always_comb begin
        w_cmd.rec_last = w_proc && w_is_rec && r_in_last;
        w_cmd.erase    = w_proc && (r_in_kind == dsrv_pkg::KIND_ERASE);
        w_cmd.commit   = w_proc && (r_in_kind == dsrv_pkg::KIND_COMMIT);
        w_cmd.slot     = r_in_slot;
    end

    dsrv_stream #(
        .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
    ) u_stream (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_proc && w_is_rec),
        .i_clear         (w_cmd.erase),
        .i_data          (r_in_data),
        .i_last          (r_in_last),
        .i_record_length (r_record_length),
        .o_verdict       (w_verdict)
    );

    dsrv_slots u_slots (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_verdict (w_verdict),
        .o_result  (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proc && w_produces) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc && w_produces) begin
            r_out <= w_result;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_record_valid      = r_out.record_valid;
    assign o_active_slot       = r_out.active_slot;
    assign o_active_generation = r_out.active_generation;
    assign o_next_generation   = r_out.next_generation;
    assign o_next_slot         = r_out.next_slot;

    a_erase_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.erase |=> o_valid && (o_active_slot == dsrv_pkg::ACT_NONE) && !o_record_valid)
        else $error("erase did not report an empty slot pair");

    a_rise_from_proc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_proc && w_produces))
        else $error("result appeared without a processed request");

    a_next_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_next_generation == o_active_generation + 32'd1)
                    && (o_next_slot == !o_next_generation[0]))
        else $error("next generation inconsistent with active generation");

    a_none_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_active_slot == dsrv_pkg::ACT_NONE) |-> (o_active_generation == 32'd0))
        else $error("no active slot but nonzero generation");

endmodule

`default_nettype wire
